@@ sv/bce_pkg.sv @@
package bce_pkg;

    localparam int CFG_W          = 11;
    localparam int PIX_W          = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int MIN_DIM        = 3;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    localparam logic [PIX_W-1:0] PIX_SET = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_CLR = 8'h00;

    // item kinds on s_axis_tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // per-item decode handed from the sequencer to the line store
    typedef struct packed {
        logic pix_go;    // pixel item taken in the frame phase
        logic flush_go;  // flush item taken in the flush phase
        logic last_col;  // item sits on the last column of its row
        logic row_nz;    // row counter nonzero: a pixel result is due
        logic inner;     // result pixel lies off the frame border
    } t_step;

endpackage

@@ sv/bce_ctrl.sv @@
module bce_ctrl
    import bce_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_fire,
    input  logic                          i_kind,
    output t_step                         o_step,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_x
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int MW   = (CW > RW) ? CW : RW;
    localparam int CMPW = ((MW > CFG_W) ? MW : CFG_W) + 2;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CW-1:0]    r_x;
    logic [RW-1:0]    r_row;
    logic             r_flushing;

    logic [CMPW-1:0] w_eff;
    logic [CMPW-1:0] h_eff;
    logic [CMPW-1:0] x_ext;
    logic [CMPW-1:0] y_ext;
    logic            last_row;
    t_step           step;

    always_comb begin
        w_eff = CMPW'(r_width);
        if (w_eff < CMPW'(MIN_DIM)) begin
            w_eff = CMPW'(MIN_DIM);
        end else if (w_eff > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        h_eff = CMPW'(r_height);
        if (h_eff < CMPW'(MIN_DIM)) begin
            h_eff = CMPW'(MIN_DIM);
        end else if (h_eff > CMPW'(MAX_HEIGHT)) begin
            h_eff = CMPW'(MAX_HEIGHT);
        end
    end

    assign x_ext    = CMPW'(r_x);
    assign y_ext    = CMPW'(r_row);
    assign last_row = (y_ext + CMPW'(1)) >= h_eff;

    always_comb begin
        step.pix_go   = i_fire && !r_flushing && (i_kind == KIND_PIXEL);
        step.flush_go = i_fire && r_flushing && (i_kind == KIND_FLUSH);
        step.last_col = (x_ext + CMPW'(1)) >= w_eff;
        step.row_nz   = (r_row != '0);
        // result row is row-1: it must be neither the top nor the bottom row
        step.inner    = (y_ext >= CMPW'(2)) && ((y_ext + CMPW'(1)) <= h_eff)
                     && (x_ext >= CMPW'(1)) && ((x_ext + CMPW'(2)) <= w_eff);
    end

    assign o_step = step;
    assign o_x    = r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_row      <= '0;
            r_flushing <= 1'b0;
        end else if (step.pix_go) begin
            if (step.last_col) begin
                r_x <= '0;
                if (last_row) begin
                    r_flushing <= 1'b1;
                    r_row      <= '0;
                end else begin
                    r_row <= r_row + RW'(1);
                end
            end else begin
                r_x <= r_x + CW'(1);
            end
        end else if (step.flush_go) begin
            if (step.last_col) begin
                r_x        <= '0;
                r_row      <= '0;
                r_flushing <= 1'b0;
            end else begin
                r_x <= r_x + CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_flush_row_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flushing |-> (r_row == '0))
        else $error("row counter nonzero during flush");

    a_flush_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step.flush_go && step.last_col) |=> (r_x == '0 && !r_flushing))
        else $error("flush did not return to frame start");

    a_frame_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step.pix_go && step.last_col && last_row) |=> r_flushing)
        else $error("last frame pixel did not start the flush");
`endif

endmodule

@@ sv/bce_line.sv @@
module bce_line
    import bce_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_step                         i_step,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x,
    input  logic                          i_cur,
    output logic                          o_set
);

    localparam int CW = $clog2(MAX_WIDTH);

    // bit0: set bit of previous row, bit1: the row before it
    logic [1:0] r_mem [MAX_WIDTH];

    logic [1:0]    r_rd;      // prefetched entry for column x+1
    logic          r_wrap;    // first column of a row: right entry comes from r_e1
    logic [1:0]    r_ent_c;   // entry for the current column
    logic [1:0]    r_e0;      // copies of entries 0 and 1 for the row turn
    logic [1:0]    r_e1;
    logic          r_left;

    logic [1:0]    ent_r;
    logic [1:0]    wr_data;
    logic [CW:0]   ahead;
    logic [CW-1:0] rd_addr;

    assign ent_r   = r_wrap ? r_e1 : r_rd;
    assign wr_data = {r_ent_c[0], i_cur};
    assign ahead   = {1'b0, i_x} + (CW+1)'(2);
    assign rd_addr = (ahead < (CW+1)'(MAX_WIDTH)) ? ahead[CW-1:0] : '0;

    assign o_set = i_step.inner && r_ent_c[1] && r_ent_c[0] && i_cur
                && r_left && ent_r[0];

    always_ff @(posedge i_clk) begin
        if (i_step.pix_go) begin
            r_mem[i_x] <= wr_data;
            r_rd       <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.pix_go) begin
            r_ent_c <= i_step.last_col ? r_e0 : ent_r;
            if (i_x == CW'(0)) begin
                r_e0 <= wr_data;
            end
            if (i_x == CW'(1)) begin
                r_e1 <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= 1'b0;
            r_left <= 1'b0;
        end else if (i_step.pix_go) begin
            r_wrap <= i_step.last_col;
            r_left <= i_step.last_col ? 1'b0 : r_ent_c[0];
        end
    end

endmodule

@@ sv/bce_out.sv @@
module bce_out
    import bce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_data,
    input  logic             i_last,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_data,
    output logic             o_last
);

    logic             r_out_v;
    logic             r_skid_v;
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_last;
    logic [PIX_W-1:0] r_skid_data;
    logic             r_skid_last;
    logic             load;

    assign load    = !r_out_v || i_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (load) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_skid_v) begin
                r_out_data <= r_skid_data;
                r_out_last <= r_skid_last;
            end else begin
                r_out_data <= i_data;
                r_out_last <= i_last;
            end
        end else if (i_valid) begin
            r_skid_data <= i_data;
            r_skid_last <= i_last;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds an item while output stage is empty");
`endif

endmodule

@@ sv/binary_cross_erosion.sv @@
// channel   | direction | tdata                 | tuser / tlast
// ----------+-----------+-----------------------+-----------------------------
// s_axis    | in        | [7:0] pixel_in        | tuser [0] kind (0 pixel, 1 flush)
// m_axis    | out       | [7:0] pixel_out       | tlast frame_end
// i_cfg_*   | in        | index 0 width, 1 height, 11-bit data, write only
//
// One item per cycle sustained unless the output stage is full; each result is registered.
// The pixel result is formed combinationally from the line store window, with the
// line store read one column ahead so its registered read keeps pace.
// A two-entry output stage keeps s_axis_tready high while one result waits.
// Reset is synchronous, active low; the line store needs no clearing pass.
module binary_cross_erosion
    import bce_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [PIX_W-1:0] s_axis_tdata,   // [7:0] pixel_in
    input  logic             s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [PIX_W-1:0] m_axis_tdata,   // [7:0] pixel_out
    output logic             m_axis_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic             fire;
    t_step            step;
    logic [CW-1:0]    x;
    logic             set;
    logic             res_valid;
    logic [PIX_W-1:0] res_data;
    logic             res_last;

    assign fire = s_axis_tvalid && s_axis_tready;

    bce_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_kind     (s_axis_tuser),
        .o_step     (step),
        .o_x        (x)
    );

    bce_line #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_x     (x),
        .i_cur   (s_axis_tdata != '0),
        .o_set   (set)
    );

    // flush items always give a zero pixel
    assign res_valid = (step.pix_go && step.row_nz) || step.flush_go;
    assign res_data  = (step.pix_go && set) ? PIX_SET : PIX_CLR;
    assign res_last  = step.flush_go && step.last_col;

    bce_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res_data),
        .i_last  (res_last),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bce_pkg::*;

    localparam int MAX_W      = DEF_MAX_WIDTH;
    localparam int MAX_H      = DEF_MAX_HEIGHT;
    localparam int PIXEL_GOAL = 1000;
    localparam int TAIL_CYC   = 8;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pix;
    } t_px_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_eroded;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = REG_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata = '0;  // [7:0] pixel_in
    logic             s_axis_tuser = KIND_PIXEL;  // [0] kind
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [PIX_W-1:0] m_axis_tdata;  // [7:0] pixel_out
    logic             m_axis_tlast;

    t_px_item pixel_queue[$];
    t_eroded  eroded_queue[$];

    int src_idle_pct = 26;
    int snk_idle_pct = 49;
    int fail_count   = 0;
    bit in_taken     = 1'b0;

    // erosion state mirrored from the block
    logic [1:0]       row_bits [0:MAX_W-1];
    logic [1:0]       left_bits;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic             in_flush;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    binary_cross_erosion DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic predict_erosion(input logic kind, input logic [PIX_W-1:0] pix);
        int unsigned w, h, x, xi, r;
        logic [1:0]  entry;
        logic        cur, rgt, last_col, inner;
        t_eroded     res;
        w        = clamp_dim(width_reg, MAX_W);
        h        = clamp_dim(height_reg, MAX_H);
        cur      = (pix != PIX_CLR);
        x        = col_cnt;
        last_col = (x + 1 >= w);
        if (in_flush) begin
            // bottom row is all border: zeros, last one closes the frame
            if (kind == KIND_FLUSH) begin
                res.pixel_out = PIX_CLR;
                res.frame_end = last_col;
                eroded_queue.push_back(res);
                if (last_col) begin
                    in_flush = 1'b0;
                    col_cnt  = 0;
                    row_cnt  = 0;
                end else begin
                    col_cnt = x + 1;
                end
            end
        end else if (kind == KIND_PIXEL) begin
            xi    = (x < MAX_W) ? x : MAX_W - 1;
            entry = row_bits[xi];
            rgt   = (xi + 1 < MAX_W) ? row_bits[xi + 1][0] : 1'b0;
            r     = row_cnt;
            if (r >= 1) begin
                // result is for the pixel one row up
                inner = (r >= 2) && (r + 1 <= h) && (x >= 1) && (x + 2 <= w);
                res.pixel_out = (inner && entry[1] && entry[0] && cur && left_bits[0] && rgt)
                                ? PIX_SET : PIX_CLR;
                res.frame_end = 1'b0;
                eroded_queue.push_back(res);
            end
            row_bits[xi] = {entry[0], cur};
            left_bits    = {left_bits[0], entry[0]};
            if (last_col) begin
                col_cnt   = 0;
                left_bits = 2'b00;
                if (r + 1 >= h) begin
                    in_flush = 1'b1;
                    row_cnt  = 0;
                end else begin
                    row_cnt = r + 1;
                end
            end else begin
                col_cnt = x + 1;
            end
        end
    endtask

    // monitor: config tracking, prediction and result checks
    always @(posedge i_clk) begin : watch
        t_eroded want;
        if (!i_rst_n) begin
            in_taken   = 1'b0;
            left_bits  = 2'b00;
            col_cnt    = 0;
            row_cnt    = 0;
            in_flush   = 1'b0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            for (int i = 0; i < MAX_W; i++) row_bits[i] = 2'b00;
        end else begin
            in_taken = s_axis_tvalid && s_axis_tready;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WIDTH) width_reg = i_cfg_data;
                else height_reg = i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (eroded_queue.size() == 0) begin
                    $error("unexpected item: pixel_out=%0d frame_end=%0b",
                           m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = eroded_queue.pop_front();
                    if (m_axis_tdata !== want.pixel_out) begin
                        $error("pixel_out: expected %0d, got %0d", want.pixel_out, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (in_taken) predict_erosion(s_axis_tuser, s_axis_tdata);
        end
    end

    // driver: source side from pixel_queue, random sink stalls
    always @(negedge i_clk) begin : drive
        t_px_item itm;
        bit       give;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || in_taken) begin
                give = (pixel_queue.size() != 0) && ($urandom_range(99) >= src_idle_pct);
                if (give) begin
                    itm = pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= itm.pix;
                    s_axis_tuser  <= itm.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic push_item(input logic kind, input logic [PIX_W-1:0] pix);
        t_px_item itm;
        itm.kind = kind;
        itm.pix  = pix;
        pixel_queue.push_back(itm);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // all items sent, all results back, then let dropped items settle
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || s_axis_tvalid || eroded_queue.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
    endtask

    // one frame plus its flush row, with wrong-kind noise sprinkled in
    task automatic run_frame(input int unsigned w, input int unsigned h, input bit hold_mid);
        int unsigned dens;
        dens = $urandom_range(100, 55);
        for (int unsigned n = 0; n < w * h; n++) begin
            if ($urandom_range(99) < 4) push_item(KIND_FLUSH, PIX_W'($urandom_range(255)));
            if ($urandom_range(99) < dens) push_item(KIND_PIXEL, PIX_W'($urandom_range(255, 1)));
            else push_item(KIND_PIXEL, PIX_CLR);
            if (hold_mid && n == w * (h / 2) + 1) wait_drained();
        end
        for (int unsigned n = 0; n < w; n++) begin
            if ($urandom_range(99) < 4) push_item(KIND_PIXEL, PIX_W'($urandom_range(255)));
            push_item(KIND_FLUSH, PIX_W'($urandom_range(255)));
        end
    endtask

    initial begin : stimulus
        int unsigned      pix_cnt, w, h, phase, cur_phase;
        logic [CFG_W-1:0] wr, hr;
        bit               first;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame, both registers below range
        write_reg(REG_WIDTH, 11'd0);
        write_reg(REG_HEIGHT, 11'd2);
        push_item(KIND_FLUSH, 8'hFF);  // flush tick mid-frame, dropped
        push_item(KIND_PIXEL, 8'h00);
        push_item(KIND_PIXEL, 8'hFF);
        push_item(KIND_PIXEL, 8'h01);
        push_item(KIND_PIXEL, 8'h80);
        push_item(KIND_PIXEL, 8'h7F);  // only inner pixel, fully surrounded
        push_item(KIND_PIXEL, 8'hFE);
        push_item(KIND_PIXEL, 8'h55);
        push_item(KIND_PIXEL, 8'hAA);
        push_item(KIND_PIXEL, 8'h10);
        push_item(KIND_FLUSH, 8'h00);
        push_item(KIND_PIXEL, 8'hFF);  // pixel during flush, dropped
        push_item(KIND_FLUSH, 8'h3C);
        push_item(KIND_FLUSH, 8'hC3);
        wait_drained();

        pix_cnt   = 0;
        cur_phase = 0;
        first     = 1'b1;
        w         = MIN_DIM;
        h         = MIN_DIM;
        while (pix_cnt < PIXEL_GOAL) begin
            phase = pix_cnt * 3 / PIXEL_GOAL;
            if (phase != cur_phase) begin
                wait_drained();
                cur_phase = phase;
                if (phase == 1) begin
                    src_idle_pct = 49;
                    snk_idle_pct = 26;
                end else begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            end
            // half the frames keep the dims and stream back to back
            if (first || $urandom_range(1)) begin
                wr = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(48, 13))
                                              : CFG_W'($urandom_range(12, 3));
                hr = CFG_W'($urandom_range(7, 3));
                if ($urandom_range(9) == 0) wr = CFG_W'($urandom_range(2));
                if ($urandom_range(9) == 0) hr = CFG_W'($urandom_range(2));
                wait_drained();
                write_reg(REG_WIDTH, wr);
                write_reg(REG_HEIGHT, hr);
                w = clamp_dim(wr, MAX_W);
                h = clamp_dim(hr, MAX_H);
            end
            run_frame(w, h, first);
            first   = 1'b0;
            pix_cnt += w * (h + 1);
        end

        // both registers above range, then shrunk mid-frame to close the frame
        wait_drained();
        write_reg(REG_WIDTH, 11'd2047);
        write_reg(REG_HEIGHT, 11'd2047);
        for (int n = 0; n < 20; n++) push_item(KIND_PIXEL, PIX_W'($urandom_range(255)));
        wait_drained();
        write_reg(REG_WIDTH, 11'd4);
        write_reg(REG_HEIGHT, 11'd3);
        // one pixel ends the long top row, then two rows of four
        for (int n = 0; n < 9; n++) push_item(KIND_PIXEL, PIX_W'($urandom_range(255, 1)));
        for (int n = 0; n < 4; n++) push_item(KIND_FLUSH, PIX_W'($urandom_range(255)));
        wait_drained();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
